### rtl/she_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions for the stereo harmonic exciter
// no dependencies; imported by she_div, she_core and the top level

package she_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int SCALE_SH      = 25 - SAMPLE_BITS;
	localparam int TANH_SEGMENTS = 64;
	localparam int IDX_W         = $clog2(TANH_SEGMENTS);
	localparam int FRAC_W        = 26 - IDX_W;
	localparam int KNOT_W        = 25;
	localparam int QUO_W         = 25;
	localparam int MAG_W         = 40;

	localparam logic signed [65:0] MAX40 = 66'sd549755813887;
	localparam logic signed [65:0] MIN40 = -66'sd549755813888;
	localparam logic signed [65:0] ONE24 = 66'sd16777216;
	localparam logic signed [65:0] SMAX  = (66'sd1 <<< (SAMPLE_BITS - 1)) - 66'sd1;
	localparam logic signed [65:0] SMIN  = -(66'sd1 <<< (SAMPLE_BITS - 1));

	// twice the knot spacing in q30
	localparam longint unsigned KNOT_STEP2 = (64'd8 << 30) / TANH_SEGMENTS;

	// configuration register indexes
	localparam logic [2:0] REG_HPC   = 3'd0;
	localparam logic [2:0] REG_LPC   = 3'd1;
	localparam logic [2:0] REG_DRIVE = 3'd2;
	localparam logic [2:0] REG_BLEND = 3'd3;
	localparam logic [2:0] REG_WET   = 3'd4;

	typedef struct packed {
		logic [15:0] hpc;
		logic [15:0] lpc;
		logic [12:0] drive;
		logic [16:0] blend;
		logic [16:0] wet;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic                          clip;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_HPSUM, ST_HPMUL, ST_HPOUT, ST_DRVMUL, ST_DRVOUT,
		ST_SQLO, ST_SQHI, ST_TANH, ST_ODD, ST_BL0, ST_BL1, ST_BL2,
		ST_LPMUL, ST_LPOUT, ST_DIV, ST_WMUL, ST_OUT, ST_DONE
	} state_t;

	typedef logic [KNOT_W-1:0] knot_arr_t [0:TANH_SEGMENTS];

	// unsigned quotient by compare and subtract, elaboration only
	function automatic longint unsigned cdiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned rem;
		longint unsigned quo;
		int              i;
		rem = '0;
		quo = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			quo = quo << 1;
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | 64'd1;
			end
		end
		return quo;
	endfunction

	// tanh knots in q0.24, evaluated at elaboration only
	function automatic knot_arr_t build_knots();
		knot_arr_t       kn;
		longint unsigned q30;
		longint unsigned a;
		longint unsigned term;
		longint unsigned p;
		longint unsigned y;
		int              n;
		int              k;
		q30  = 64'd1 << 30;
		a    = KNOT_STEP2;
		term = q30;
		y    = q30;
		p    = q30;
		for (n = 1; n <= 20; n++) begin
			term = cdiv(term * a, 64'(n) << 30);
			if (n[0]) y = y - term;
			else y = y + term;
		end
		kn[0] = '0;
		for (k = 1; k <= TANH_SEGMENTS; k++) begin
			p = (p * y + (q30 >> 1)) >> 30;
			if (p > q30) p = q30;
			kn[k] = KNOT_W'(cdiv(((q30 - p) << 24) + ((q30 + p) >> 1), q30 + p));
		end
		return kn;
	endfunction

	localparam knot_arr_t KNOTS = build_knots();

	function automatic logic signed [65:0] sat40(input logic signed [65:0] v);
		logic signed [65:0] r;
		r = v;
		if (v > MAX40) r = MAX40;
		if (v < MIN40) r = MIN40;
		return r;
	endfunction

	// right shift rounding half away from zero
	function automatic logic signed [65:0] rshr(input logic signed [65:0] v, input int s);
		logic [65:0] mg;
		mg = v[65] ? 66'(-v) : 66'(v);
		mg = (mg + (66'(1) << (s - 1))) >> s;
		return v[65] ? -$signed(mg) : $signed(mg);
	endfunction

	function automatic logic [MAG_W-1:0] mag40(input logic signed [39:0] v);
		logic signed [40:0] w;
		w = 41'(v);
		return v[39] ? MAG_W'(-w) : MAG_W'(w);
	endfunction

endpackage

### rtl/she_mul.sv
`timescale 1ns / 1ps
// shared signed multiplier with registered product
// depends on nothing; its operands are muxed in she_core

module she_mul (
	input  logic               clk,
	input  logic signed [41:0] a,
	input  logic signed [21:0] b,
	output logic signed [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

### rtl/she_div.sv
`timescale 1ns / 1ps
// restoring divider for the normalization |x| * 2^24 / (|x| + 2^24), rounded
// depends on she_pkg

module she_div import she_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] mag,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	logic [40:0]      den_q;
	logic [40:0]      rem_q;
	logic [QUO_W-1:0] bits_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [40:0]      den_w;
	logic [64:0]      num_w;
	logic [41:0]      trial;
	logic             ge;
	logic [40:0]      rem_n;

	always_comb begin
		den_w = 41'(mag) + 41'(ONE24);
		num_w = 65'({mag, 24'b0}) + 65'(den_w >> 1);
		trial = {rem_q, bits_q[QUO_W-1]};
		ge    = trial >= 42'(den_q);
		rem_n = ge ? 41'(trial - 42'(den_q)) : trial[40:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den_w;
			rem_q  <= 41'(num_w[64:QUO_W]);
			bits_q <= num_w[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q  <= rem_n;
			bits_q <= {bits_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = bits_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q) else $error("divider done while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == 5'(QUO_W - 1) && !start) |=> done_q)
		else $error("divider missed its done");
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> bits_q <= QUO_W'(ONE24)) else $error("quotient above one");

endmodule

### rtl/she_core.sv
`timescale 1ns / 1ps
// sequencer and datapath for both channels, filter state and shaping steps
// depends on she_pkg, she_mul and she_div

module she_core import she_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	input  cfg_t                          cfg,
	input  logic                          out_free,
	output logic                          idle,
	output logic                          done,
	output res_t                          res
);

	state_t state_q, state_d;
	logic   ch_q;

	logic signed [SAMPLE_BITS-1:0] left_q, right_q;
	logic signed [39:0]            hp_q [2];
	logic signed [SAMPLE_BITS-1:0] prev_q [2];
	logic signed [39:0]            lp_q [2];

	logic signed [41:0]       t_q;
	logic signed [39:0]       h_q;
	logic [MAG_W-1:0]         m_q;
	logic [KNOT_W-1:0]        lo_q;
	logic signed [25:0]       d_q;
	logic signed [65:0]       acc_q;
	logic signed [39:0]       ev_q;
	logic signed [39:0]       od_q;
	logic signed [25:0]       nq_q;
	logic signed [SAMPLE_BITS-1:0] resl_q, resr_q;
	logic                     clip_q;

	logic signed [41:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [63:0] p;
	logic signed [65:0] p66;

	logic                          div_start;
	logic [MAG_W-1:0]              div_mag;
	logic                          div_done;
	logic [QUO_W-1:0]              div_quo;

	logic signed [SAMPLE_BITS-1:0] cur_s;
	logic signed [65:0]            x_w;
	logic signed [65:0]            hp_sum, hp_new, drv_h, sq_t, ev_w, tv, od_w;
	logic signed [65:0]            bl_h, lp_new, o_w;
	logic [16:0]                   bcl, wcl;
	logic [IDX_W:0]                kidx;
	logic signed [25:0]            d_w;
	logic [MAG_W-1:0]              drv_m;

	she_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(p));

	she_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .mag(div_mag),
		.done(div_done), .quo(div_quo)
	);

	always_comb begin
		p66    = 66'(p);
		cur_s  = ch_q ? right_q : left_q;
		x_w    = 66'(cur_s) <<< SCALE_SH;
		bcl    = cfg.blend[16] ? 17'd65536 : cfg.blend;
		wcl    = cfg.wet[16] ? 17'd65536 : cfg.wet;
		hp_sum = sat40(66'(hp_q[ch_q]) + x_w - (66'(prev_q[ch_q]) <<< SCALE_SH));
		hp_new = sat40(rshr(p66, 16));
		drv_h  = sat40(rshr(p66, 8));
		drv_m  = mag40(drv_h[39:0]);
		kidx   = {1'b0, m_q[FRAC_W +: IDX_W]};
		d_w    = $signed(26'(KNOTS[kidx + (IDX_W+1)'(1)])) - $signed(26'(KNOTS[kidx]));
		// even shaper: h + 0.5*h*|h|, square assembled from two half products
		sq_t   = (acc_q + (p66 <<< 16) + ONE24) >>> 25;
		if (m_q[MAG_W-1:32] != '0) ev_w = h_q[39] ? MIN40 : MAX40;
		else ev_w = sat40(h_q[39] ? 66'(h_q) - sq_t : 66'(h_q) + sq_t);
		// interpolated tanh, one from four upward
		tv     = $signed({41'b0, lo_q}) + rshr(p66, FRAC_W);
		if (m_q[MAG_W-1:26] != '0) tv = ONE24;
		od_w   = h_q[39] ? -tv : tv;
		bl_h   = sat40(rshr(acc_q + p66, 16));
		lp_new = sat40(66'(lp_q[ch_q]) + rshr(p66, 16));
		o_w    = rshr(x_w + rshr(p66, 16), SCALE_SH);
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_HPMUL: begin
				mul_a = t_q;
				mul_b = {6'b0, cfg.hpc};
			end
			ST_DRVMUL: begin
				mul_a = t_q;
				mul_b = {9'b0, cfg.drive};
			end
			ST_SQLO: begin
				mul_a = {10'b0, m_q[31:0]};
				mul_b = {6'b0, m_q[15:0]};
			end
			ST_SQHI: begin
				mul_a = {10'b0, m_q[31:0]};
				mul_b = {6'b0, m_q[31:16]};
			end
			ST_TANH: begin
				mul_a = 42'(d_q);
				mul_b = 22'({1'b0, m_q[FRAC_W-1:0]});
			end
			ST_BL0: begin
				mul_a = 42'(ev_q);
				mul_b = {4'b0, 18'(18'd65536 - 18'(bcl))};
			end
			ST_BL1: begin
				mul_a = 42'(od_q);
				mul_b = {5'b0, bcl};
			end
			ST_LPMUL: begin
				mul_a = t_q;
				mul_b = {6'b0, cfg.lpc};
			end
			ST_WMUL: begin
				mul_a = 42'(nq_q);
				mul_b = {5'b0, wcl};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		done      = 1'b0;
		div_start = 1'b0;
		div_mag   = mag40(lp_new[39:0]);
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_HPSUM;
			ST_HPSUM:  state_d = ST_HPMUL;
			ST_HPMUL:  state_d = ST_HPOUT;
			ST_HPOUT:  state_d = ST_DRVMUL;
			ST_DRVMUL: state_d = ST_DRVOUT;
			ST_DRVOUT: state_d = ST_SQLO;
			ST_SQLO:   state_d = ST_SQHI;
			ST_SQHI:   state_d = ST_TANH;
			ST_TANH:   state_d = ST_ODD;
			ST_ODD:    state_d = ST_BL0;
			ST_BL0:    state_d = ST_BL1;
			ST_BL1:    state_d = ST_BL2;
			ST_BL2:    state_d = ST_LPMUL;
			ST_LPMUL:  state_d = ST_LPOUT;
			ST_LPOUT: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV:    if (div_done) state_d = ST_WMUL;
			ST_WMUL:   state_d = ST_OUT;
			ST_OUT:    state_d = ch_q ? ST_DONE : ST_HPSUM;
			ST_DONE: begin
				done = out_free;
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= 1'b0;
			clip_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				hp_q[i]   <= '0;
				prev_q[i] <= '0;
				lp_q[i]   <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: if (start) begin
					ch_q   <= 1'b0;
					clip_q <= 1'b0;
				end
				ST_HPOUT: begin
					hp_q[ch_q]   <= hp_new[39:0];
					prev_q[ch_q] <= cur_s;
				end
				ST_LPOUT: lp_q[ch_q] <= lp_new[39:0];
				ST_OUT: begin
					ch_q <= ~ch_q;
					if (o_w > SMAX || o_w < SMIN) clip_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				left_q  <= left_in;
				right_q <= right_in;
			end
			ST_HPSUM:  t_q <= 42'($signed(hp_sum[39:0]));
			ST_HPOUT:  t_q <= 42'($signed(hp_new[39:0]));
			ST_DRVOUT: begin
				h_q <= drv_h[39:0];
				m_q <= drv_m;
			end
			ST_SQLO: begin
				lo_q <= KNOTS[kidx];
				d_q  <= d_w;
			end
			ST_SQHI:   acc_q <= p66;
			ST_TANH:   ev_q <= ev_w[39:0];
			ST_ODD:    od_q <= od_w[39:0];
			ST_BL1:    acc_q <= p66;
			ST_BL2:    t_q <= 42'(bl_h - 66'(lp_q[ch_q]));
			ST_DIV: if (div_done) begin
				nq_q <= lp_q[ch_q][39] ? -$signed(26'(div_quo)) : $signed(26'(div_quo));
			end
			ST_OUT: begin
				if (ch_q) begin
					resr_q <= o_w > SMAX ? SAMPLE_BITS'(SMAX) :
						(o_w < SMIN ? SAMPLE_BITS'(SMIN) : o_w[SAMPLE_BITS-1:0]);
				end else begin
					resl_q <= o_w > SMAX ? SAMPLE_BITS'(SMAX) :
						(o_w < SMIN ? SAMPLE_BITS'(SMIN) : o_w[SAMPLE_BITS-1:0]);
				end
			end
			default: ;
		endcase
	end

	assign idle       = (state_q == ST_IDLE);
	assign res.left   = resl_q;
	assign res.right  = resr_q;
	assign res.clip   = clip_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q != ST_IDLE) |=> state_q != ST_HPSUM || $past(state_q) == ST_OUT)
		else $error("start taken while busy");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("divider result not awaited");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == ST_IDLE) else $error("sequencer did not return to idle");
	a_right_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> $past(ch_q) || $past(state_q) == ST_DONE)
		else $error("finished before right channel");

endmodule

### rtl/stereo_harmonic_exciter.sv
`timescale 1ns / 1ps
// top level of the stereo harmonic exciter: configuration registers, handshakes
// depends on she_pkg and she_core (which uses she_mul and she_div)

// One item is a stereo pair of q1.15 samples; each channel passes a one-pole
// high-pass, the drive gain, a blend of the even shaper h+0.5h|h| with a
// 64-segment piecewise-linear tanh, a one-pole low-pass, the normalization
// x/(1+|x|) and a wet mix onto the dry sample, then saturates to 16 bits.
// The channels run one after the other through a single shared 42x22
// multiplier under a sequencer: per channel 16 sequencer steps plus a wait
// on the one-bit-per-cycle divider used for the normalization (25 quotient
// bits, then its done strobe), and after the right channel the pair is
// handed to the output register. in_ready is high only while the sequencer
// is idle, so the next item is accepted only after the last one has left it.
// A finished result sits in an output register, so the next item is
// accepted while it waits; the sequencer stalls only if a second result is
// ready before the first is taken. Configuration writes land at once and are
// meant to happen while no item is in flight; unknown indexes are ignored.
// The odd blend and wet mix saturate at one.

module stereo_harmonic_exciter import she_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	// input item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	// result item channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_result,
	output logic signed [SAMPLE_BITS-1:0] right_result,
	output logic                          clipped,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [16:0]                   cfg_data
);

	cfg_t cfg_q;
	res_t core_res;
	res_t res_q;
	logic out_valid_q;
	logic core_idle;
	logic core_done;
	logic out_free;

	// configuration registers, reset to the nominal voicing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hpc   <= 16'd47063;
			cfg_q.lpc   <= 16'd57464;
			cfg_q.drive <= 13'd2816;
			cfg_q.blend <= 17'd32768;
			cfg_q.wet   <= 17'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HPC:   cfg_q.hpc   <= cfg_data[15:0];
				REG_LPC:   cfg_q.lpc   <= cfg_data[15:0];
				REG_DRIVE: cfg_q.drive <= cfg_data[12:0];
				REG_BLEND: cfg_q.blend <= cfg_data;
				REG_WET:   cfg_q.wet   <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register frees up in the same cycle it is taken
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = core_idle;

	she_core u_core (
		.clk(clk), .arst_n(arst_n),
		.start(in_valid && in_ready),
		.left_in(left_sample), .right_in(right_sample),
		.cfg(cfg_q), .out_free(out_free),
		.idle(core_idle), .done(core_done), .res(core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (core_done) res_q <= core_res;
	end

	assign out_valid    = out_valid_q;
	assign left_result  = res_q.left;
	assign right_result = res_q.right;
	assign clipped      = res_q.clip;

endmodule

### dv/stereo_harmonic_exciter_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the stereo harmonic exciter: drives sample pairs,
// predicts each processed pair in a scoreboard class and compares results
// depends on she_pkg and the rtl of stereo_harmonic_exciter

module stereo_harmonic_exciter_test;
	import she_pkg::*;

	// exciter predictor and store of expected processed pairs
	class exciter_scoreboard;
		longint tanh_knot [0:TANH_SEGMENTS];
		longint hp_state [2];
		longint hp_prev [2];
		longint lp_state [2];
		longint unsigned hpc, lpc, drive, blend, wet;
		res_t pending_pairs [$];
		int mismatches;

		function void reset_state();
			longint unsigned q30, a, term, p, y;
			q30 = 64'd1 << 30;
			a = (64'd8 << 30) / TANH_SEGMENTS;
			term = q30;
			y = q30;
			p = q30;
			for (int n = 1; n <= 20; n++) begin
				term = (term * a) / (64'(n) << 30);
				if (n % 2 == 1) y = y - term;
				else y = y + term;
			end
			tanh_knot[0] = 0;
			for (int k = 1; k <= TANH_SEGMENTS; k++) begin
				p = (p * y + (q30 >> 1)) >> 30;
				if (p > q30) p = q30;
				tanh_knot[k] = ((((q30 - p) << 24) + ((q30 + p) >> 1)) / (q30 + p));
			end
			hpc = 47063; lpc = 57464; drive = 2816; blend = 32768; wet = 65536;
			for (int c = 0; c < 2; c++) begin
				hp_state[c] = 0; hp_prev[c] = 0; lp_state[c] = 0;
			end
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [16:0] value);
			case (idx)
				REG_HPC:   hpc = value[15:0];
				REG_LPC:   lpc = value[15:0];
				REG_DRIVE: drive = value[12:0];
				REG_BLEND: blend = value;
				REG_WET:   wet = value;
				default: ;
			endcase
		endfunction

		function longint clamp40(longint v);
			if (v > 64'sd549755813887) return 64'sd549755813887;
			if (v < -64'sd549755813888) return -64'sd549755813888;
			return v;
		endfunction

		// wide product rounded half away from zero
		function longint round_shift(logic signed [127:0] v, int s);
			logic [127:0] mg;
			mg = v < 0 ? -v : v;
			mg = (mg + (128'd1 << (s - 1))) >> s;
			return v < 0 ? -longint'(mg) : longint'(mg);
		endfunction

		function longint tanh_pwl(longint h);
			longint unsigned m, pos, idx;
			longint r, lo, hi, v;
			m = h < 0 ? -h : h;
			if (m >= (64'd4 << 24)) v = 64'sd16777216;
			else begin
				pos = m * TANH_SEGMENTS;
				idx = pos >> 26;
				r = pos & ((64'd1 << 26) - 1);
				lo = tanh_knot[idx];
				hi = tanh_knot[idx + 1];
				v = lo + round_shift(128'(hi - lo) * r, 26);
			end
			return h < 0 ? -v : v;
		endfunction

		function longint even_shaper(longint h);
			longint unsigned m;
			longint t;
			m = h < 0 ? -h : h;
			if (m >= (64'd1 << 32)) return h < 0 ? -64'sd549755813888 : 64'sd549755813887;
			t = (m * m + (64'd1 << 24)) >> 25;
			return clamp40(h < 0 ? h - t : h + t);
		endfunction

		function longint soft_norm(longint x);
			longint unsigned m, den;
			longint q;
			m = x < 0 ? -x : x;
			den = m + 64'd16777216;
			q = ((m << 24) + (den >> 1)) / den;
			return x < 0 ? -q : q;
		endfunction

		function longint excite_channel(int c, longint s, ref bit clip);
			longint x, h, ev, od, o;
			longint unsigned b, w;
			b = blend > 65536 ? 65536 : blend;
			w = wet > 65536 ? 65536 : wet;
			x = s * 512;
			h = clamp40(hp_state[c] + x - hp_prev[c] * 512);
			hp_state[c] = clamp40(round_shift(128'(longint'(hpc)) * h, 16));
			hp_prev[c] = s;
			h = clamp40(round_shift(128'(hp_state[c]) * longint'(drive), 8));
			ev = even_shaper(h);
			od = tanh_pwl(h);
			h = clamp40(round_shift(128'(longint'(65536 - b)) * ev
				+ 128'(longint'(b)) * od, 16));
			lp_state[c] = clamp40(lp_state[c]
				+ round_shift(128'(longint'(lpc)) * (h - lp_state[c]), 16));
			o = x + round_shift(128'(longint'(w)) * soft_norm(lp_state[c]), 16);
			o = round_shift(128'(o), 9);
			if (o > 32767) begin o = 32767; clip = 1; end
			if (o < -32768) begin o = -32768; clip = 1; end
			return o;
		endfunction

		function void note_input(logic signed [15:0] l, logic signed [15:0] r);
			res_t e;
			bit clip;
			clip = 0;
			e.left = 16'(excite_channel(0, l, clip));
			e.right = 16'(excite_channel(1, r, clip));
			e.clip = clip;
			pending_pairs.push_back(e);
		endfunction

		function void report(string what, int got, int want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
			mismatches++;
		endfunction

		function void check_result(logic signed [15:0] l, logic signed [15:0] r, logic c);
			res_t e;
			if (pending_pairs.size() == 0) begin
				report("unexpected item", 1, 0);
				return;
			end
			e = pending_pairs.pop_front();
			if (l !== e.left) report("left_result", l, e.left);
			if (r !== e.right) report("right_result", r, e.right);
			if (c !== e.clip) report("clipped", c, e.clip);
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [15:0] left_sample, right_sample, left_result, right_result;
	logic clipped, cfg_we;
	logic [2:0] cfg_index;
	logic [16:0] cfg_data;

	exciter_scoreboard pair_board;
	int send_idle_pct, recv_idle_pct;
	longint cycle_count = 0;
	int items_sent = 0;
	int results_seen = 0;

	stereo_harmonic_exciter i_dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// the run ends here once the overall cycle budget runs out, as when the block stops moving
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: random stalls, every accepted item is checked
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			pair_board.check_result(left_result, right_result, clipped);
			results_seen++;
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one item, held until accepted; random idle cycles before it
	task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		left_sample <= l;
		right_sample <= r;
		do @(posedge clk); while (!in_ready);
		pair_board.note_input(l, r);
		items_sent++;
	endtask

	// wait for all results, then settle
	task automatic drain();
		in_valid <= 0;
		while (pair_board.pending_pairs.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [16:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		pair_board.write_reg(idx, value);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// random samples: half full scale, a quarter small, a quarter near the rails
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(3))
			0: return 16'($urandom_range(255) - 128);
			1: return $urandom_range(1) ? 16'(16'sh7fff - $urandom_range(15))
				: 16'(16'sh8000 + $urandom_range(15));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic random_burst(int n);
		for (int i = 0; i < n; i++) send_pair(pick_sample(), pick_sample());
	endtask

	// a full register setting, written only while the block is idle
	task automatic set_regs(int h, int lp, int d, int b, int w);
		write_reg(REG_HPC, 17'(h));
		write_reg(REG_LPC, 17'(lp));
		write_reg(REG_DRIVE, 17'(d));
		write_reg(REG_BLEND, 17'(b));
		write_reg(REG_WET, 17'(w));
	endtask

	initial begin
		pair_board = new();
		pair_board.reset_state();
		arst_n = 0;
		in_valid = 0;
		left_sample = 0;
		right_sample = 0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = REG_HPC;
		cfg_data = 0;
		send_idle_pct = 8;
		recv_idle_pct = 73;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, steps and zero at reset settings
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);
		send_pair(0, 0);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(1, -1);
		send_pair(16'sh5555, 16'shaaaa);
		drain();
		// extremes: max drive, pure tanh, blend and wet above one, unknown index
		set_regs(65535, 65535, 8191, 131071, 131071);
		write_reg(3'd7, 17'h1ffff);
		write_reg(3'd5, 17'h0);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);
		send_pair(16'sh4000, -16'sh4000);
		send_pair(0, 0);
		drain();
		// zero coefficients, minimum drive, pure even shaper, dry only
		set_regs(0, 0, 0, 0, 0);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh1234, -16'sh1234);
		drain();
		set_regs(65535, 65535, 5376, 0, 65536);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh0100, 16'sh0200);
		drain();
		set_regs(47063, 57464, 256, 65536, 65536);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);

		// random phases under several settings and idle patterns
		random_burst(300);
		drain();
		set_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(8191),
			$urandom_range(131071), $urandom_range(131071));
		random_burst(300);
		drain();
		send_idle_pct = 73;
		recv_idle_pct = 8;
		set_regs(47063, 57464, 2816, 32768, 65536);
		random_burst(300);
		drain();
		set_regs($urandom_range(65535), $urandom_range(65535),
			$urandom_range(5376, 256), $urandom_range(65536), $urandom_range(65536));
		random_burst(300);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_regs(65535, 65535, 5376, 65536, 65536);
		random_burst(300);
		drain();
		set_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(8191),
			$urandom_range(131071), $urandom_range(131071));
		random_burst(376);
		drain();

		$display("covered %0d sample pairs and %0d results across several register settings",
			items_sent, results_seen);
		$display("idle patterns: sender heavy, receiver heavy and none");
		if (pair_board.mismatches == 0 && pair_board.pending_pairs.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
